// ===== src/assert_macros.svh =====
// assertion macros shared by the planner rtl
// no dependencies; define ASSERT_OFF to drop every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold on every clock edge outside reset
`define TMP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define TMP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TMP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/tmp_pkg.sv =====
// shared types and constants of the trapezoidal motion planner
// no dependencies
package tmp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PER_W       = 16;
    localparam int POS_W       = 40;
    localparam int VEL_W       = 32;
    localparam int LIM_W       = 31;
    localparam int DIFF_W      = POS_W + 1;
    localparam int LO_W        = 32;
    localparam int MH_W        = DIFF_W - LO_W;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int RAD_W       = 64;
    localparam int BAND_W      = 22;
    localparam int RECIP_SHIFT = 41;
    localparam logic [31:0] RECIP = 32'd2199023256;
    localparam int SQ_CNT_W    = 5;
    localparam logic [SQ_CNT_W-1:0] SQ_LAST = 5'd31;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 31;
    localparam int IN_W        = 96;
    localparam int OUT_W       = 152;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_MAX_VEL_AZ  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_ACC_AZ  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ENABLE_AZ   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MAX_VEL_ELV = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MAX_ACC_ELV = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_ENABLE_ELV  = 3'd5;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DV, OP_BANDP, OP_BANDQ, OP_MAG, OP_DD, OP_PLO,
        OP_PHI, OP_RAD1, OP_RAD2, OP_SQRT, OP_VREQ, OP_VEL, OP_POS, OP_FIN
    } tmp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DV, ST_BANDP, ST_BANDQ, ST_MAG, ST_DD, ST_PLO, ST_PHI,
        ST_RAD1, ST_RAD2, ST_SQRT, ST_VREQ, ST_VEL, ST_POS, ST_FIN
    } tmp_state_t;

    typedef struct packed {
        tmp_op_t op;
        logic    axis;
    } tmp_cmd_t;

    typedef struct packed {
        logic need;
    } tmp_sts_t;

endpackage

// ===== src/tmp_ctrl.sv =====
// sequencer of the planner: steps both axes through the shared datapath
// depends on tmp_pkg and assert_macros.svh
`include "assert_macros.svh"
module tmp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  tmp_pkg::tmp_sts_t sts,
    output tmp_pkg::tmp_cmd_t cmd
);

    tmp_pkg::tmp_state_t        state_reg, state_next;
    logic                       axis_reg, axis_next;
    logic [tmp_pkg::SQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                       valid_reg, valid_next;
    logic                       out_free;

    assign out_free = !valid_reg || m_tready;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmp_pkg::ST_IDLE;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        case (state_reg)
            tmp_pkg::ST_IDLE:  if (s_tvalid) state_next = tmp_pkg::ST_DV;
            tmp_pkg::ST_DV:    state_next = tmp_pkg::ST_BANDP;
            tmp_pkg::ST_BANDP: state_next = tmp_pkg::ST_BANDQ;
            tmp_pkg::ST_BANDQ: state_next = tmp_pkg::ST_MAG;
            tmp_pkg::ST_MAG:   state_next = tmp_pkg::ST_DD;
            tmp_pkg::ST_DD:
                state_next = sts.need ? tmp_pkg::ST_PLO : tmp_pkg::ST_VREQ;
            tmp_pkg::ST_PLO:   state_next = tmp_pkg::ST_PHI;
            tmp_pkg::ST_PHI:   state_next = tmp_pkg::ST_RAD1;
            tmp_pkg::ST_RAD1:  state_next = tmp_pkg::ST_RAD2;
            tmp_pkg::ST_RAD2:
            begin
                state_next = tmp_pkg::ST_SQRT;
                cnt_next   = '0;
            end
            tmp_pkg::ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tmp_pkg::SQ_LAST) state_next = tmp_pkg::ST_VREQ;
            end
            tmp_pkg::ST_VREQ:  state_next = tmp_pkg::ST_VEL;
            tmp_pkg::ST_VEL:   state_next = tmp_pkg::ST_POS;
            tmp_pkg::ST_POS:
            begin
                if (axis_reg)
                    state_next = tmp_pkg::ST_FIN;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = tmp_pkg::ST_DV;
                end
            end
            tmp_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    axis_next  = 1'b0;
                    valid_next = 1'b1;
                    state_next = tmp_pkg::ST_IDLE;
                end
            end
            default:           state_next = tmp_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.axis = axis_reg;
        cmd.op   = tmp_pkg::OP_NONE;
        s_tready = 1'b0;
        case (state_reg)
            tmp_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = tmp_pkg::OP_LOAD;
            end
            tmp_pkg::ST_DV:    cmd.op = tmp_pkg::OP_DV;
            tmp_pkg::ST_BANDP: cmd.op = tmp_pkg::OP_BANDP;
            tmp_pkg::ST_BANDQ: cmd.op = tmp_pkg::OP_BANDQ;
            tmp_pkg::ST_MAG:   cmd.op = tmp_pkg::OP_MAG;
            tmp_pkg::ST_DD:    cmd.op = tmp_pkg::OP_DD;
            tmp_pkg::ST_PLO:   cmd.op = tmp_pkg::OP_PLO;
            tmp_pkg::ST_PHI:   cmd.op = tmp_pkg::OP_PHI;
            tmp_pkg::ST_RAD1:  cmd.op = tmp_pkg::OP_RAD1;
            tmp_pkg::ST_RAD2:  cmd.op = tmp_pkg::OP_RAD2;
            tmp_pkg::ST_SQRT:  cmd.op = tmp_pkg::OP_SQRT;
            tmp_pkg::ST_VREQ:  cmd.op = tmp_pkg::OP_VREQ;
            tmp_pkg::ST_VEL:   cmd.op = tmp_pkg::OP_VEL;
            tmp_pkg::ST_POS:   cmd.op = tmp_pkg::OP_POS;
            tmp_pkg::ST_FIN:   if (out_free) cmd.op = tmp_pkg::OP_FIN;
            default:           cmd.op = tmp_pkg::OP_NONE;
        endcase
    end

    assign m_tvalid = valid_reg;

    // checks
    `TMP_ASSERT(a_fin_valid, clk, rst_n, (state_reg == tmp_pkg::ST_FIN && out_free) |=> valid_reg, "result not posted")
    `TMP_ASSERT(a_sqrt_end, clk, rst_n, (state_reg == tmp_pkg::ST_SQRT && cnt_reg == tmp_pkg::SQ_LAST) |=> (state_reg == tmp_pkg::ST_VREQ), "root did not finish")
    `TMP_ASSERT_NEVER(a_idle_axis, clk, rst_n, state_reg == tmp_pkg::ST_IDLE && axis_reg, "idle on second axis")
    `TMP_ASSERT(a_accept_start, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg == tmp_pkg::ST_DV && !axis_reg), "beat not started")

endmodule

// ===== src/tmp_datapath.sv =====
// datapath of the planner: axis state, shared multiplier, integer root
// depends on tmp_pkg
module tmp_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tmp_pkg::tmp_cmd_t           cmd,
    output tmp_pkg::tmp_sts_t           sts,
    input  logic                        cfg_we,
    input  logic [tmp_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [tmp_pkg::CFG_DW-1:0]  cfg_data,
    input  logic [tmp_pkg::PER_W-1:0]   tick_period,
    input  logic [tmp_pkg::POS_W-1:0]   cmd_in_az,
    input  logic [tmp_pkg::POS_W-1:0]   cmd_in_elv,
    output logic [tmp_pkg::POS_W-1:0]   out_pos_az,
    output logic [tmp_pkg::POS_W-1:0]   out_pos_elv,
    output logic [tmp_pkg::VEL_W-1:0]   out_vel_az,
    output logic [tmp_pkg::VEL_W-1:0]   out_vel_elv,
    output logic                        moving_az,
    output logic                        moving_elv
);

    localparam int POS_W  = tmp_pkg::POS_W;
    localparam int VEL_W  = tmp_pkg::VEL_W;
    localparam int LIM_W  = tmp_pkg::LIM_W;
    localparam int FB     = tmp_pkg::FRAC_BITS;
    localparam int DIFF_W = tmp_pkg::DIFF_W;
    localparam int LO_W   = tmp_pkg::LO_W;
    localparam int MH_W   = tmp_pkg::MH_W;
    localparam int MUL_W  = tmp_pkg::MUL_W;
    localparam int PROD_W = tmp_pkg::PROD_W;
    localparam int RAD_W  = tmp_pkg::RAD_W;
    localparam int BAND_W = tmp_pkg::BAND_W;
    localparam int RS     = tmp_pkg::RECIP_SHIFT;
    localparam int PER_W  = tmp_pkg::PER_W;
    localparam int VX_W   = VEL_W + 2;

    // axis state and configuration
    logic [POS_W-1:0] tgt_reg [2];
    logic [POS_W-1:0] pos_reg [2];
    logic [VEL_W-1:0] vel_reg [2];
    logic [LIM_W-1:0] max_vel_reg [2];
    logic [LIM_W-1:0] max_acc_reg [2];
    logic             en_reg [2];
    logic             active_reg [2];

    // working registers
    logic [PER_W-1:0]    per_reg;
    logic [POS_W-1:0]    cmd_az_reg, cmd_elv_reg;
    logic [LIM_W-1:0]    d_reg, tmp_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [DIFF_W-1:0]   mag_reg;
    logic                neg_reg, need_reg, ovf_reg;
    logic [2*LIM_W-1:0]  dd_reg;
    logic [RAD_W-1:0]    plo_reg, rad_reg, x_reg, r_reg, b_reg;
    logic [MH_W+LO_W-1:0] phi_reg;
    logic [VEL_W-1:0]    vreq_reg;
    logic [POS_W-1:0]    opos_az_reg, opos_elv_reg;
    logic [VEL_W-1:0]    ovel_az_reg, ovel_elv_reg;
    logic                omov_az_reg, omov_elv_reg;

    logic                ax;
    logic [LIM_W-1:0]    acc, lim;
    logic [LO_W-1:0]     a2;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [LIM_W-1:0]    dv_sat;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]   mag;
    logic [RAD_W:0]      p_sum, r_sum;
    logic [RAD_W-1:0]    sq_t;
    logic signed [VX_W-1:0] r_x, d_x, lim_x, raw, vreq_x, vel_x, vp, vm;
    logic [VEL_W-1:0]    vel_new;
    logic signed [VEL_W-1:0] delta;
    logic signed [DIFF_W-1:0] psum;
    logic [POS_W-1:0]    pos_new;

    assign ax  = cmd.axis;
    assign acc = max_acc_reg[ax];
    assign lim = max_vel_reg[ax];
    assign a2  = {acc, 1'b0};

    // shared multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            tmp_pkg::OP_DV:
            begin
                mul_a = $signed({2'b0, acc});
                mul_b = $signed({{(MUL_W-PER_W){1'b0}}, per_reg});
            end
            tmp_pkg::OP_BANDP:
            begin
                mul_a = $signed({2'b0, d_reg});
                mul_b = $signed({{(MUL_W-PER_W){1'b0}}, per_reg});
            end
            tmp_pkg::OP_BANDQ:
            begin
                mul_a = $signed({2'b0, tmp_reg});
                mul_b = $signed({1'b0, tmp_pkg::RECIP});
            end
            tmp_pkg::OP_DD:
            begin
                mul_a = $signed({2'b0, d_reg});
                mul_b = $signed({2'b0, d_reg});
            end
            tmp_pkg::OP_PLO:
            begin
                mul_a = $signed({1'b0, a2});
                mul_b = $signed({1'b0, mag_reg[LO_W-1:0]});
            end
            tmp_pkg::OP_PHI:
            begin
                mul_a = $signed({1'b0, a2});
                mul_b = $signed({{(MUL_W-MH_W){1'b0}}, mag_reg[DIFF_W-1:LO_W]});
            end
            tmp_pkg::OP_POS:
            begin
                mul_a = $signed({vel_reg[ax][VEL_W-1], vel_reg[ax]});
                mul_b = $signed({{(MUL_W-PER_W){1'b0}}, per_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // acceleration step per tick, saturated
    assign dv_sat = (|prod[PROD_W-1:LIM_W+FB]) ? {LIM_W{1'b1}} : prod[LIM_W+FB-1:FB];

    // position error
    assign diff = $signed({tgt_reg[ax][POS_W-1], tgt_reg[ax]})
                - $signed({pos_reg[ax][POS_W-1], pos_reg[ax]});
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // radicand assembly with saturation
    assign p_sum = {1'b0, plo_reg} + {1'b0, phi_reg[LO_W-1:0], {LO_W{1'b0}}};
    assign r_sum = {1'b0, rad_reg} + {{(RAD_W+1-2*LIM_W){1'b0}}, dd_reg};

    // one root step
    assign sq_t = r_reg + b_reg;

    // requested velocity from the braking curve, clipped
    assign r_x   = $signed({2'b0, r_reg[VEL_W-1:0]});
    assign d_x   = $signed({3'b0, d_reg});
    assign lim_x = $signed({3'b0, lim});
    always_comb
    begin
        if (!need_reg)
            raw = '0;
        else if (neg_reg)
            raw = d_x - r_x;
        else
            raw = r_x - d_x;
        if (raw > lim_x)
            vreq_x = lim_x;
        else if (raw < -lim_x)
            vreq_x = -lim_x;
        else
            vreq_x = raw;
    end

    // velocity slew
    assign vel_x = $signed({{2{vel_reg[ax][VEL_W-1]}}, vel_reg[ax]});
    assign vp    = vel_x + d_x;
    assign vm    = vel_x - d_x;
    always_comb
    begin
        if ($signed({{2{vreq_reg[VEL_W-1]}}, vreq_reg}) > vp)
            vel_new = vp[VEL_W-1:0];
        else if ($signed({{2{vreq_reg[VEL_W-1]}}, vreq_reg}) < vm)
            vel_new = vm[VEL_W-1:0];
        else
            vel_new = vreq_reg;
    end

    // position integration, floor of the scaled product, saturated
    assign delta = prod[VEL_W+FB-1:FB];
    assign psum  = $signed({pos_reg[ax][POS_W-1], pos_reg[ax]})
                 + $signed({{(DIFF_W-VEL_W){delta[VEL_W-1]}}, delta});
    always_comb
    begin
        if (psum[DIFF_W-1] != psum[DIFF_W-2])
            pos_new = delta[VEL_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                     : {1'b0, {(POS_W-1){1'b1}}};
        else
            pos_new = psum[POS_W-1:0];
    end

    // configuration and axis state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                tgt_reg[i]     <= '0;
                pos_reg[i]     <= '0;
                vel_reg[i]     <= '0;
                max_vel_reg[i] <= '0;
                max_acc_reg[i] <= '0;
                en_reg[i]      <= 1'b0;
                active_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    tmp_pkg::CFG_MAX_VEL_AZ:  max_vel_reg[0] <= cfg_data;
                    tmp_pkg::CFG_MAX_ACC_AZ:  max_acc_reg[0] <= cfg_data;
                    tmp_pkg::CFG_ENABLE_AZ:   en_reg[0]      <= cfg_data[0];
                    tmp_pkg::CFG_MAX_VEL_ELV: max_vel_reg[1] <= cfg_data;
                    tmp_pkg::CFG_MAX_ACC_ELV: max_acc_reg[1] <= cfg_data;
                    tmp_pkg::CFG_ENABLE_ELV:  en_reg[1]      <= cfg_data[0];
                    default: ;
                endcase
            end
            case (cmd.op)
                tmp_pkg::OP_VEL:
                begin
                    vel_reg[ax]    <= vel_new;
                    active_reg[ax] <= need_reg || (vel_new != '0);
                end
                tmp_pkg::OP_POS: pos_reg[ax] <= pos_new;
                tmp_pkg::OP_FIN:
                begin
                    tgt_reg[0] <= cmd_az_reg;
                    tgt_reg[1] <= cmd_elv_reg;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tmp_pkg::OP_LOAD:
            begin
                per_reg     <= tick_period;
                cmd_az_reg  <= cmd_in_az;
                cmd_elv_reg <= cmd_in_elv;
            end
            tmp_pkg::OP_DV:    d_reg    <= dv_sat;
            tmp_pkg::OP_BANDP: tmp_reg  <= prod[LIM_W+FB-1:FB];
            tmp_pkg::OP_BANDQ: band_reg <= prod[RS+BAND_W-1:RS];
            tmp_pkg::OP_MAG:
            begin
                mag_reg  <= mag;
                neg_reg  <= diff[DIFF_W-1];
                need_reg <= en_reg[ax] && (mag > {{(DIFF_W-BAND_W){1'b0}}, band_reg});
            end
            tmp_pkg::OP_DD:    dd_reg   <= prod[2*LIM_W-1:0];
            tmp_pkg::OP_PLO:   plo_reg  <= prod[RAD_W-1:0];
            tmp_pkg::OP_PHI:   phi_reg  <= prod[MH_W+LO_W-1:0];
            tmp_pkg::OP_RAD1:
            begin
                rad_reg <= p_sum[RAD_W-1:0];
                ovf_reg <= (|phi_reg[MH_W+LO_W-1:LO_W]) || p_sum[RAD_W];
            end
            tmp_pkg::OP_RAD2:
            begin
                x_reg <= (ovf_reg || r_sum[RAD_W]) ? {RAD_W{1'b1}} : r_sum[RAD_W-1:0];
                r_reg <= '0;
                b_reg <= {2'b01, {(RAD_W-2){1'b0}}};
            end
            tmp_pkg::OP_SQRT:
            begin
                if (x_reg >= sq_t)
                begin
                    x_reg <= x_reg - sq_t;
                    r_reg <= (r_reg >> 1) + b_reg;
                end
                else
                    r_reg <= r_reg >> 1;
                b_reg <= b_reg >> 2;
            end
            tmp_pkg::OP_VREQ:  vreq_reg <= vreq_x[VEL_W-1:0];
            tmp_pkg::OP_FIN:
            begin
                opos_az_reg  <= pos_reg[0];
                opos_elv_reg <= pos_reg[1];
                ovel_az_reg  <= vel_reg[0];
                ovel_elv_reg <= vel_reg[1];
                omov_az_reg  <= active_reg[0];
                omov_elv_reg <= active_reg[1];
            end
            default: ;
        endcase
    end

    assign sts.need    = need_reg;
    assign out_pos_az  = opos_az_reg;
    assign out_pos_elv = opos_elv_reg;
    assign out_vel_az  = ovel_az_reg;
    assign out_vel_elv = ovel_elv_reg;
    assign moving_az   = omov_az_reg;
    assign moving_elv  = omov_elv_reg;

endmodule

// ===== src/trapezoidal_motion_planner.sv =====
// the sequencer steps each axis in turn through the shared multiplier and, for an
// enabled axis outside the dead band, the bit-pair root unit (32-step root per
// axis); a new input beat is taken only in idle, once the result beat of the
// last one has been posted to the output register
// reset: asynchronous, clears axis state, limits and enables to zero
// depends on tmp_pkg, tmp_ctrl and tmp_datapath
module trapezoidal_motion_planner
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tmp_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [tmp_pkg::CFG_DW-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // tick_period[15:0], cmd_in_az[55:16], cmd_in_elv[95:56]
    input  logic [tmp_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_pos_az[39:0], out_pos_elv[79:40], out_vel_az[111:80],
    // out_vel_elv[143:112], moving_az[144], moving_elv[145], zero fill
    output logic [tmp_pkg::OUT_W-1:0]   m_tdata
);

    tmp_pkg::tmp_cmd_t cmd;
    tmp_pkg::tmp_sts_t sts;

    logic [tmp_pkg::POS_W-1:0] pos_az, pos_elv;
    logic [tmp_pkg::VEL_W-1:0] vel_az, vel_elv;
    logic                      mov_az, mov_elv;

    // sequencer
    tmp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic and state
    tmp_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .tick_period (s_tdata[15:0]),
        .cmd_in_az   (s_tdata[55:16]),
        .cmd_in_elv  (s_tdata[95:56]),
        .out_pos_az  (pos_az),
        .out_pos_elv (pos_elv),
        .out_vel_az  (vel_az),
        .out_vel_elv (vel_elv),
        .moving_az   (mov_az),
        .moving_elv  (mov_elv)
    );

    // result beat packing
    assign m_tdata = {6'b0, mov_elv, mov_az, vel_elv, vel_az, pos_elv, pos_az};

endmodule
